// ===== hw/rtl/mono_rect_draw_engine_macros.svh =====
// Assertion macros used by the port checker of the drawing engine.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef MONO_RECT_DRAW_ENGINE_MACROS_SVH
`define MONO_RECT_DRAW_ENGINE_MACROS_SVH

// Concurrent assertion clocked on clk_i and disabled while rst_ni is low.
`define MRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define MRD_ASSERT_NEXT(lbl, ante, cons) \
  `MRD_ASSERT(lbl, (ante) |=> (cons))

`endif

// ===== hw/rtl/mrd_pkg.sv =====
// Package of the drawing engine: sizes, opcodes, region phases and the
// command and status words between controller and datapath. No dependencies.
package mrd_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 128;
  localparam int StoreDepth = (MaxWidth / 8) * MaxHeight;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int BarScale   = 100;

  // The fill division by BarScale is a multiplication by a rounded-up
  // reciprocal, exact for every dividend below 2**22.
  localparam int          BarShift = 29;
  localparam logic [22:0] BarRecip = 23'd5368710;

  localparam logic [2:0] OpClear = 3'd0;
  localparam logic [2:0] OpRect  = 3'd1;
  localparam logic [2:0] OpHline = 3'd2;
  localparam logic [2:0] OpBar   = 3'd3;
  localparam logic [2:0] OpRead  = 3'd4;

  localparam logic [3:0] PhOuter = 4'd0;
  localparam logic [3:0] PhFill  = 4'd1;
  localparam logic [3:0] PhTop   = 4'd2;
  localparam logic [3:0] PhBot   = 4'd3;
  localparam logic [3:0] PhLeft  = 4'd4;
  localparam logic [3:0] PhRight = 4'd5;
  localparam logic [3:0] PhIfill = 4'd6;
  localparam logic [3:0] PhIbg   = 4'd7;
  localparam logic [3:0] PhFrame = 4'd8;
  localparam logic [3:0] PhEnd   = 4'd9;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic       latch;
    logic       load;
    logic [3:0] phase;
    logic       box_grow;
    logic       box_full;
    logic       walk_init;
    logic       mem_rd;
    logic       mem_wr;
    logic       div_start;
    logic       div_step;
    logic       rd_byte;
    logic       result;
  } mrd_cmd_t;

  typedef struct packed {
    logic empty;
    logic walk_last;
    logic div_done;
    logic bar_ok;
  } mrd_sts_t;

endpackage

// ===== hw/rtl/mrd_dp.sv =====
// Datapath of the drawing engine: command latch, clipping, byte walk,
// framebuffer memory, bar divider, dirty box and result registers. Uses mrd_pkg.
module mrd_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mrd_pkg::mrd_cmd_t         cmd_i,
  output mrd_pkg::mrd_sts_t         sts_o,
  input  logic [2:0]                opcode_i,
  input  logic signed [15:0]        pos_x_i,
  input  logic signed [15:0]        pos_y_i,
  input  logic signed [15:0]        size_w_i,
  input  logic signed [15:0]        size_h_i,
  input  logic                      ink_i,
  input  logic [7:0]                percent_i,
  input  logic [mrd_pkg::AddrW-1:0] read_address_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [8:0]                cfg_data_i,
  output logic                      done_o,
  output logic [7:0]                read_data_o,
  output logic                      dirty_valid_o,
  output logic [8:0]                dirty_x0_o,
  output logic [7:0]                dirty_y0_o,
  output logic [8:0]                dirty_x1_o,
  output logic [7:0]                dirty_y1_o
);

  logic [8:0] width_q, height_raw_q;
  logic [8:0] eff_w, w_masked;
  logic [7:0] eff_h;
  logic [5:0] stride;

  logic [2:0]                op_q;
  logic signed [15:0]        x_q, y_q, w_q, h_q;
  logic                      ink_q;
  logic [6:0]                pct_q;
  logic [mrd_pkg::AddrW-1:0] addr_q;

  logic signed [19:0] xs, ys, ws, hs, fws;
  logic signed [19:0] rx, ry, rw, rh, sx1, sy1, cx0, cy0, cx1, cy1, wext, hext;
  logic               ph_ink, clip_empty;

  logic [8:0] rx0_q, rx1_q;
  logic [7:0] ry0_q, ry1_q;
  logic       empty_q, rink_q;

  logic [7:0]                row_q;
  logic [mrd_pkg::AddrW-1:0] base_q, waddr, raddr;
  logic [4:0]                col_q, bfirst, blast;
  logic [8:0]                xl;
  logic [7:0]                ry1m;
  logic [2:0]                lo, hi;
  logic [7:0]                mask, wdata;
  logic [13:0]               base_init;
  logic                      last;

  logic [7:0] mem [mrd_pkg::StoreDepth];
  logic [7:0] rdata_q;

  logic [21:0] quot_q, product;
  logic [44:0] recip;
  logic        dcnt_q;
  logic [14:0] iw;

  logic       bvalid_q;
  logic [8:0] bl_q, br_q;
  logic [7:0] bt_q, bb_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= 9'(mrd_pkg::MaxWidth);
      height_raw_q <= 9'(mrd_pkg::MaxHeight);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == mrd_pkg::CfgWidth) begin
        width_q <= cfg_data_i;
      end else begin
        height_raw_q <= {1'b0, cfg_data_i[7:0]};
      end
    end
  end

  assign w_masked = {width_q[8:3], 3'b000};
  always_comb begin
    if (w_masked == 9'd0) begin
      eff_w = 9'd8;
    end else if (w_masked > 9'(mrd_pkg::MaxWidth)) begin
      eff_w = 9'(mrd_pkg::MaxWidth);
    end else begin
      eff_w = w_masked;
    end
    if (height_raw_q == 9'd0) begin
      eff_h = 8'd1;
    end else if (height_raw_q > 9'(mrd_pkg::MaxHeight)) begin
      eff_h = 8'(mrd_pkg::MaxHeight);
    end else begin
      eff_h = height_raw_q[7:0];
    end
  end
  assign stride = eff_w[8:3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= opcode_i;
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      w_q    <= size_w_i;
      h_q    <= (opcode_i == mrd_pkg::OpHline) ? 16'sd1 : size_h_i;
      ink_q  <= (opcode_i == mrd_pkg::OpBar) ? 1'b1 : ink_i;
      pct_q  <= (percent_i > 8'(mrd_pkg::BarScale)) ? 7'(mrd_pkg::BarScale)
                                                    : percent_i[6:0];
      addr_q <= read_address_i;
    end
  end

  assign xs   = 20'(x_q);
  assign ys   = 20'(y_q);
  assign ws   = 20'(w_q);
  assign hs   = 20'(h_q);
  assign fws  = signed'({5'b00000, quot_q[14:0]});
  assign wext = signed'({11'd0, eff_w});
  assign hext = signed'({12'd0, eff_h});

  always_comb begin
    rx = xs;
    ry = ys;
    rw = ws;
    rh = hs;
    ph_ink = ink_q;
    unique case (cmd_i.phase)
      mrd_pkg::PhTop: begin
        rh = 20'sd1;
      end
      mrd_pkg::PhBot: begin
        ry = ys + hs - 20'sd1;
        rh = (hs != 20'sd1) ? 20'sd1 : 20'sd0;
      end
      mrd_pkg::PhLeft: begin
        rw = 20'sd1;
      end
      mrd_pkg::PhRight: begin
        rx = xs + ws - 20'sd1;
        rw = (ws != 20'sd1) ? 20'sd1 : 20'sd0;
      end
      mrd_pkg::PhIfill: begin
        rx = xs + 20'sd1;
        ry = ys + 20'sd1;
        rw = fws;
        rh = hs - 20'sd2;
        ph_ink = 1'b1;
      end
      mrd_pkg::PhIbg: begin
        rx = xs + 20'sd1 + fws;
        ry = ys + 20'sd1;
        rw = ws - 20'sd2 - fws;
        rh = hs - 20'sd2;
        ph_ink = 1'b0;
      end
      mrd_pkg::PhFrame: begin
        rx = 20'sd0;
        ry = 20'sd0;
        rw = wext;
        rh = hext;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sx1 = rx + rw;
    sy1 = ry + rh;
    cx0 = rx[19] ? 20'sd0 : rx;
    cy0 = ry[19] ? 20'sd0 : ry;
    cx1 = (sx1 > wext) ? wext : sx1;
    cy1 = (sy1 > hext) ? hext : sy1;
    clip_empty = (rw <= 20'sd0) || (rh <= 20'sd0) || (cx1 <= cx0) || (cy1 <= cy0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b1;
    end else if (cmd_i.load) begin
      empty_q <= clip_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rx0_q  <= cx0[8:0];
      rx1_q  <= cx1[8:0];
      ry0_q  <= cy0[7:0];
      ry1_q  <= cy1[7:0];
      rink_q <= ph_ink;
    end
  end

  assign xl        = rx1_q - 9'd1;
  assign ry1m      = ry1_q - 8'd1;
  assign bfirst    = rx0_q[7:3];
  assign blast     = xl[7:3];
  assign last      = (col_q == blast) && (row_q == ry1m);
  assign base_init = ry0_q * stride;
  assign waddr     = base_q + {7'd0, col_q};
  assign raddr     = cmd_i.rd_byte ? addr_q : waddr;
  assign lo        = (col_q == bfirst) ? rx0_q[2:0] : 3'd0;
  assign hi        = (col_q == blast) ? xl[2:0] : 3'd7;
  assign mask      = (8'hFF >> lo) & (8'hFF << (3'd7 - hi));
  assign wdata     = rink_q ? (rdata_q & ~mask) : (rdata_q | mask);

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      row_q  <= ry0_q;
      base_q <= base_init[mrd_pkg::AddrW-1:0];
      col_q  <= bfirst;
    end else if (cmd_i.mem_wr && !last) begin
      if (col_q == blast) begin
        col_q  <= bfirst;
        row_q  <= row_q + 8'd1;
        base_q <= base_q + {6'd0, stride};
      end else begin
        col_q <= col_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[raddr];
    end
  end

  assign iw      = w_q[14:0] - 15'd2;
  assign product = pct_q * iw;
  assign recip   = quot_q * mrd_pkg::BarRecip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= 1'b1;
    end else if (cmd_i.div_step) begin
      dcnt_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quot_q <= product;
    end else if (cmd_i.div_step && dcnt_q) begin
      quot_q <= 22'(recip >> mrd_pkg::BarShift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
      bl_q     <= '0;
      bt_q     <= '0;
      br_q     <= '0;
      bb_q     <= '0;
    end else if (cmd_i.box_full) begin
      bvalid_q <= 1'b1;
      bl_q     <= '0;
      bt_q     <= '0;
      br_q     <= eff_w;
      bb_q     <= eff_h;
    end else if (cmd_i.box_grow) begin
      bvalid_q <= 1'b1;
      if (!bvalid_q || rx0_q < bl_q) bl_q <= rx0_q;
      if (!bvalid_q || ry0_q < bt_q) bt_q <= ry0_q;
      if (!bvalid_q || rx1_q > br_q) br_q <= rx1_q;
      if (!bvalid_q || ry1_q > bb_q) bb_q <= ry1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      read_data_o   <= (op_q == mrd_pkg::OpRead) ? rdata_q : 8'h00;
      dirty_valid_o <= bvalid_q;
      dirty_x0_o    <= bl_q;
      dirty_y0_o    <= bt_q;
      dirty_x1_o    <= br_q;
      dirty_y1_o    <= bb_q;
    end
  end

  assign sts_o.empty     = empty_q;
  assign sts_o.walk_last = last;
  assign sts_o.div_done  = !dcnt_q;
  assign sts_o.bar_ok    = (w_q >= 16'sd3) && (h_q >= 16'sd3);

endmodule

// ===== hw/rtl/mrd_ctrl.sv =====
// Controller of the drawing engine: sequences region phases, byte
// read-modify-write steps, the bar divider and the result. Uses mrd_pkg.
module mrd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        opcode_i,
  input  logic              solid_i,
  input  mrd_pkg::mrd_sts_t sts_i,
  output mrd_pkg::mrd_cmd_t cmd_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SClip  = 3'd1;
  localparam logic [2:0] SCheck = 3'd2;
  localparam logic [2:0] SRd    = 3'd3;
  localparam logic [2:0] SWr    = 3'd4;
  localparam logic [2:0] SDiv   = 3'd5;
  localparam logic [2:0] SRdb   = 3'd6;
  localparam logic [2:0] SDone  = 3'd7;

  logic [2:0] state_q, state_d, op_q, op_d;
  logic [3:0] phase_q, phase_d, np;
  logic       solid_q, solid_d, adv;

  function automatic logic [3:0] next_ph(logic [2:0] op, logic solid, logic [3:0] ph,
                                         logic bar_ok);
    logic [3:0] r;
    r = mrd_pkg::PhEnd;
    unique case (ph)
      mrd_pkg::PhOuter: begin
        if (op == mrd_pkg::OpHline || (op == mrd_pkg::OpRect && solid)) begin
          r = mrd_pkg::PhFill;
        end else begin
          r = mrd_pkg::PhTop;
        end
      end
      mrd_pkg::PhTop:   r = mrd_pkg::PhBot;
      mrd_pkg::PhBot:   r = mrd_pkg::PhLeft;
      mrd_pkg::PhLeft:  r = mrd_pkg::PhRight;
      mrd_pkg::PhRight: r = (op == mrd_pkg::OpBar && bar_ok) ? mrd_pkg::PhIfill
                                                              : mrd_pkg::PhEnd;
      mrd_pkg::PhIfill: r = mrd_pkg::PhIbg;
      default:          r = mrd_pkg::PhEnd;
    endcase
    return r;
  endfunction

  assign np   = next_ph(op_q, solid_q, phase_q, sts_i.bar_ok);
  assign busy = (state_q != SIdle);

  always_comb begin
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    state_d     = state_q;
    phase_d     = phase_q;
    op_d        = op_q;
    solid_d     = solid_q;
    adv         = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          op_d        = opcode_i;
          solid_d     = solid_i;
          if (opcode_i == mrd_pkg::OpClear) begin
            phase_d = mrd_pkg::PhFrame;
            state_d = SClip;
          end else if (opcode_i == mrd_pkg::OpRect || opcode_i == mrd_pkg::OpHline ||
                       opcode_i == mrd_pkg::OpBar) begin
            phase_d = mrd_pkg::PhOuter;
            state_d = SClip;
          end else if (opcode_i == mrd_pkg::OpRead) begin
            state_d = SRdb;
          end else begin
            state_d = SDone;
          end
        end
      end
      SClip: begin
        cmd_o.load = 1'b1;
        state_d    = SCheck;
      end
      SCheck: begin
        if (phase_q == mrd_pkg::PhOuter) begin
          if (sts_i.empty) begin
            state_d = SDone;
          end else begin
            cmd_o.box_grow = 1'b1;
            adv            = 1'b1;
          end
        end else if (sts_i.empty) begin
          adv = 1'b1;
        end else begin
          cmd_o.box_full  = (phase_q == mrd_pkg::PhFrame);
          cmd_o.walk_init = 1'b1;
          state_d         = SRd;
        end
      end
      SRd: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = SWr;
      end
      SWr: begin
        cmd_o.mem_wr = 1'b1;
        if (sts_i.walk_last) begin
          adv = 1'b1;
        end else begin
          state_d = SRd;
        end
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = SClip;
        end
      end
      SRdb: begin
        cmd_o.rd_byte = 1'b1;
        cmd_o.mem_rd  = 1'b1;
        state_d       = SDone;
      end
      SDone: begin
        cmd_o.result = 1'b1;
        state_d      = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    if (adv) begin
      if (np == mrd_pkg::PhEnd) begin
        state_d = SDone;
      end else begin
        phase_d = np;
        if (np == mrd_pkg::PhIfill) begin
          cmd_o.div_start = 1'b1;
          state_d         = SDiv;
        end else begin
          state_d = SClip;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      phase_q <= mrd_pkg::PhOuter;
      op_q    <= mrd_pkg::OpClear;
      solid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      op_q    <= op_d;
      solid_q <= solid_d;
    end
  end

endmodule

// ===== hw/rtl/mono_rect_draw_engine.sv =====
// Top level of the 1-bit-per-pixel drawing engine with dirty box.
// Instantiates mrd_ctrl and mrd_dp; uses mrd_pkg.
//
// A command word is taken when start is high and busy is low. Each command
// returns one result word on the result ports, flagged by done_o for one
// cycle; the receiver must take it then, there is no back-pressure.
// Geometry registers are written via cfg_valid_i/cfg_ready_o, cfg_index_i
// (0 width, 1 height) and cfg_data_i, by the user only while no command
// runs; the block does not enforce it. Steps from acceptance to done_o:
//   read byte: the byte read, then the result; unused opcodes: the result.
//   drawing: each region phase is clipped and checked, and each framebuffer
//   byte touched is a read then a write on the single framebuffer port.
//   a bar also runs the reciprocal fill division before its inner fill.
//   clear: the whole frame as one region, each byte a read then a write.
// One command runs at a time; a new one may start in the cycle done_o shows.
// Reset empties the dirty box and sets 256 x 128; the framebuffer holds
// whatever it held and must be cleared or drawn before it is read.
module mono_rect_draw_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                opcode_i,
  input  logic signed [15:0]        pos_x_i,
  input  logic signed [15:0]        pos_y_i,
  input  logic signed [15:0]        size_w_i,
  input  logic signed [15:0]        size_h_i,
  input  logic                      ink_i,
  input  logic                      solid_i,
  input  logic [7:0]                percent_i,
  input  logic [mrd_pkg::AddrW-1:0] read_address_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [8:0]                cfg_data_i,
  output logic                      done_o,
  output logic [7:0]                read_data_o,
  output logic                      dirty_valid_o,
  output logic [8:0]                dirty_x0_o,
  output logic [7:0]                dirty_y0_o,
  output logic [8:0]                dirty_x1_o,
  output logic [7:0]                dirty_y1_o
);

  mrd_pkg::mrd_cmd_t cmd;
  mrd_pkg::mrd_sts_t sts;

  mrd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .opcode_i (opcode_i),
    .solid_i  (solid_i),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  mrd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (opcode_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .size_w_i       (size_w_i),
    .size_h_i       (size_h_i),
    .ink_i          (ink_i),
    .percent_i      (percent_i),
    .read_address_i (read_address_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .dirty_valid_o  (dirty_valid_o),
    .dirty_x0_o     (dirty_x0_o),
    .dirty_y0_o     (dirty_y0_o),
    .dirty_x1_o     (dirty_x1_o),
    .dirty_y1_o     (dirty_y1_o)
  );

endmodule

// ===== hw/rtl/mrd_chk.sv =====
// Port checker of the drawing engine, bound to the top level.
// Uses the assertion macros header and mrd_pkg.
`include "mono_rect_draw_engine_macros.svh"

module mrd_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [2:0]                opcode_i,
  input logic signed [15:0]        pos_x_i,
  input logic signed [15:0]        pos_y_i,
  input logic signed [15:0]        size_w_i,
  input logic signed [15:0]        size_h_i,
  input logic                      ink_i,
  input logic                      solid_i,
  input logic [7:0]                percent_i,
  input logic [mrd_pkg::AddrW-1:0] read_address_i,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic                      cfg_index_i,
  input logic [8:0]                cfg_data_i,
  input logic                      done_o,
  input logic [7:0]                read_data_o,
  input logic                      dirty_valid_o,
  input logic [8:0]                dirty_x0_o,
  input logic [7:0]                dirty_y0_o,
  input logic [8:0]                dirty_x1_o,
  input logic [7:0]                dirty_y1_o
);

  `MRD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `MRD_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `MRD_ASSERT(a_done_idle, done_o |-> !busy)
  `MRD_ASSERT(a_box_order, (done_o && dirty_valid_o) |->
    (dirty_x1_o > dirty_x0_o && dirty_y1_o > dirty_y0_o))

endmodule

bind mono_rect_draw_engine mrd_chk u_mrd_chk (.*);

// ===== tb/mrd_checker.sv =====
// Checker of the drawing engine: watches commands, geometry writes and result words,
// keeps its own framebuffer and dirty box, and compares every result word.
// Depends on mrd_pkg for sizes and opcodes.
`timescale 1ns / 100ps

module mrd_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  logic [2:0]                opcode_i,
  input  logic signed [15:0]        pos_x_i,
  input  logic signed [15:0]        pos_y_i,
  input  logic signed [15:0]        size_w_i,
  input  logic signed [15:0]        size_h_i,
  input  logic                      ink_i,
  input  logic                      solid_i,
  input  logic [7:0]                percent_i,
  input  logic [mrd_pkg::AddrW-1:0] read_address_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [8:0]                cfg_data_i,
  input  logic                      done_o,
  input  logic [7:0]                read_data_o,
  input  logic                      dirty_valid_o,
  input  logic [8:0]                dirty_x0_o,
  input  logic [7:0]                dirty_y0_o,
  input  logic [8:0]                dirty_x1_o,
  input  logic [7:0]                dirty_y1_o,
  output int                        fail_count,
  output int                        words_pending
);

  typedef struct packed {
    logic [7:0] rdata;
    logic       dvalid;
    logic [8:0] x0;
    logic [7:0] y0;
    logic [8:0] x1;
    logic [7:0] y1;
  } status_word_t;

  logic [7:0]   frame_mem [mrd_pkg::StoreDepth];
  logic [8:0]   geom_w;
  logic [7:0]   geom_h;
  logic         box_on;
  int           box_l, box_t, box_r, box_b;
  status_word_t expected_words[$];

  function automatic int width_px();
    int w;
    w = int'(geom_w) & ~7;
    if (w < 8) w = 8;
    if (w > mrd_pkg::MaxWidth) w = mrd_pkg::MaxWidth;
    return w;
  endfunction

  function automatic int height_px();
    int h;
    h = int'(geom_h);
    if (h < 1) h = 1;
    if (h > mrd_pkg::MaxHeight) h = mrd_pkg::MaxHeight;
    return h;
  endfunction

  function automatic void plot(int x, int y, logic ink);
    int idx;
    logic [7:0] mask;
    if (x < 0 || y < 0 || x >= width_px() || y >= height_px()) return;
    idx = y * (width_px() / 8) + x / 8;
    mask = 8'h80 >> (x % 8);
    if (ink) frame_mem[idx] = frame_mem[idx] & ~mask;
    else frame_mem[idx] = frame_mem[idx] | mask;
  endfunction

  function automatic void grow(int x0, int y0, int x1, int y1);
    if (x1 <= x0 || y1 <= y0) return;
    if (!box_on) begin
      box_l = x0; box_t = y0; box_r = x1; box_b = y1;
      box_on = 1'b1;
      return;
    end
    if (x0 < box_l) box_l = x0;
    if (y0 < box_t) box_t = y0;
    if (x1 > box_r) box_r = x1;
    if (y1 > box_b) box_b = y1;
  endfunction

  function automatic void paint_rect(int x, int y, int w, int h, logic ink, logic fill);
    int cx0, cy0, cx1, cy1, top, bot, lft, rgt;
    if (w <= 0 || h <= 0) return;
    cx0 = (x < 0) ? 0 : x;
    cy0 = (y < 0) ? 0 : y;
    cx1 = (x + w > width_px()) ? width_px() : x + w;
    cy1 = (y + h > height_px()) ? height_px() : y + h;
    if (cx1 <= cx0 || cy1 <= cy0) return;
    top = y; bot = y + h - 1; lft = x; rgt = x + w - 1;
    if (fill) begin
      for (int j = cy0; j < cy1; j++)
        for (int i = cx0; i < cx1; i++) plot(i, j, ink);
    end else begin
      if (top >= cy0 && top < cy1)
        for (int i = cx0; i < cx1; i++) plot(i, top, ink);
      if (bot != top && bot >= cy0 && bot < cy1)
        for (int i = cx0; i < cx1; i++) plot(i, bot, ink);
      if (lft >= cx0 && lft < cx1)
        for (int j = cy0; j < cy1; j++) plot(lft, j, ink);
      if (rgt != lft && rgt >= cx0 && rgt < cx1)
        for (int j = cy0; j < cy1; j++) plot(rgt, j, ink);
    end
    grow(cx0, cy0, cx1, cy1);
  endfunction

  function automatic status_word_t run_command(logic [2:0] op, int x, int y, int w, int h,
                                               logic ink, logic solid, int pct,
                                               int addr);
    status_word_t r;
    int cx0, cx1, iw, fw, n;
    r.rdata = 8'h00;
    case (op)
      mrd_pkg::OpClear: begin
        n = (width_px() / 8) * height_px();
        for (int k = 0; k < n; k++) frame_mem[k] = ink ? 8'h00 : 8'hFF;
        box_l = 0; box_t = 0; box_r = width_px(); box_b = height_px();
        box_on = 1'b1;
      end
      mrd_pkg::OpRect: paint_rect(x, y, w, h, ink, solid);
      mrd_pkg::OpHline: begin
        if (w > 0 && y >= 0 && y < height_px()) begin
          cx0 = (x < 0) ? 0 : x;
          cx1 = (x + w > width_px()) ? width_px() : x + w;
          if (cx1 > cx0) begin
            for (int i = cx0; i < cx1; i++) plot(i, y, ink);
            grow(cx0, y, cx1, y + 1);
          end
        end
      end
      mrd_pkg::OpBar: begin
        paint_rect(x, y, w, h, 1'b1, 1'b0);
        if (w >= 3 && h >= 3) begin
          if (pct > mrd_pkg::BarScale) pct = mrd_pkg::BarScale;
          iw = w - 2;
          fw = (iw * pct) / mrd_pkg::BarScale;
          if (fw > 0) paint_rect(x + 1, y + 1, fw, h - 2, 1'b1, 1'b1);
          if (iw - fw > 0) paint_rect(x + 1 + fw, y + 1, iw - fw, h - 2, 1'b0, 1'b1);
        end
      end
      mrd_pkg::OpRead: if (addr < mrd_pkg::StoreDepth) r.rdata = frame_mem[addr];
      default: ;
    endcase
    r.dvalid = box_on;
    r.x0 = box_l[8:0];
    r.y0 = box_t[7:0];
    r.x1 = box_r[8:0];
    r.y1 = box_b[7:0];
    return r;
  endfunction

  assign words_pending = expected_words.size();

  always @(posedge clk_i or negedge rst_ni) begin
    status_word_t want, got;
    if (!rst_ni) begin
      geom_w <= 9'd256;
      geom_h <= 8'd128;
      box_on = 1'b0;
      box_l = 0; box_t = 0; box_r = 0; box_b = 0;
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (done_o) begin
        got = '{read_data_o, dirty_valid_o, dirty_x0_o, dirty_y0_o, dirty_x1_o, dirty_y1_o};
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected: %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (want != got) begin
            $display("%0t: result mismatch: expected rd=%h v=%b box=%0d,%0d,%0d,%0d",
                     $time, want.rdata, want.dvalid, want.x0, want.y0, want.x1, want.y1);
            $display("%0t:                  actual rd=%h v=%b box=%0d,%0d,%0d,%0d",
                     $time, got.rdata, got.dvalid, got.x0, got.y0, got.x1, got.y1);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        expected_words.push_back(run_command(opcode_i, int'(pos_x_i), int'(pos_y_i),
                                             int'(size_w_i), int'(size_h_i), ink_i,
                                             solid_i, int'(percent_i),
                                             int'(read_address_i)));
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == mrd_pkg::CfgWidth) geom_w <= cfg_data_i;
        else geom_h <= cfg_data_i[7:0];
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the drawing engine testbench: clock, reset, command and geometry stimulus,
// watchdog and verdict. Depends on mrd_pkg, mono_rect_draw_engine and mrd_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam int StallLimit = 40000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [2:0]                opcode_i = mrd_pkg::OpClear;
  logic signed [15:0]        pos_x_i = '0;
  logic signed [15:0]        pos_y_i = '0;
  logic signed [15:0]        size_w_i = '0;
  logic signed [15:0]        size_h_i = '0;
  logic                      ink_i = 1'b0;
  logic                      solid_i = 1'b0;
  logic [7:0]                percent_i = '0;
  logic [mrd_pkg::AddrW-1:0] read_address_i = '0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic                      cfg_index_i = mrd_pkg::CfgWidth;
  logic [8:0]                cfg_data_i = '0;
  logic                      done_o;
  logic [7:0]                read_data_o;
  logic                      dirty_valid_o;
  logic [8:0]                dirty_x0_o, dirty_x1_o;
  logic [7:0]                dirty_y0_o, dirty_y1_o;
  int                        fail_count, words_pending;
  int                        idle_pct, quiet_cycles;
  int                        cur_w, cur_h;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  mono_rect_draw_engine dut (.*);
  mrd_checker u_checker (.*);

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else if (quiet_cycles >= StallLimit) begin
      $display("mono_rect_draw_engine regression: fail");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_word(logic [2:0] op, int x, int y, int w, int h, logic ink,
                           logic solid, int pct, int addr);
    logic was_busy;
    opcode_i <= op;
    pos_x_i <= x[15:0];
    pos_y_i <= y[15:0];
    size_w_i <= w[15:0];
    size_h_i <= h[15:0];
    ink_i <= ink;
    solid_i <= solid;
    percent_i <= pct[7:0];
    read_address_i <= addr[mrd_pkg::AddrW-1:0];
    start <= 1'b1;
    forever begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
      if (!was_busy) break;
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (words_pending != 0);
    @(posedge clk_i);
  endtask

  task automatic set_geometry(int w, int h);
    logic was_ready;
    drain();
    repeat (8) @(posedge clk_i);
    for (int k = 0; k < 2; k++) begin
      cfg_index_i <= (k == 0) ? mrd_pkg::CfgWidth : mrd_pkg::CfgHeight;
      cfg_data_i <= (k == 0) ? w[8:0] : h[8:0];
      cfg_valid_i <= 1'b1;
      forever begin
        @(negedge clk_i);
        was_ready = cfg_ready_o;
        @(posedge clk_i);
        if (was_ready) break;
      end
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cur_w = w & ~7;
    if (cur_w < 8) cur_w = 8;
    if (cur_w > mrd_pkg::MaxWidth) cur_w = mrd_pkg::MaxWidth;
    cur_h = (h & 8'hFF) < 1 ? 1 : ((h & 8'hFF) > mrd_pkg::MaxHeight ? mrd_pkg::MaxHeight
                                                                    : (h & 8'hFF));
  endtask

  function automatic int pick_coord(int span);
    if ($urandom_range(15) == 0) return int'($signed(16'($urandom())));
    return $urandom_range(span + 40) - 20;
  endfunction

  function automatic int pick_size();
    case ($urandom_range(19))
      0: return int'($signed(16'($urandom())));
      1: return -$urandom_range(3);
      2: return $urandom_range(300);
      default: return $urandom_range(24);
    endcase
  endfunction

  task automatic random_word();
    int sel;
    logic [2:0] op;
    sel = $urandom_range(99);
    if (sel < 2) op = mrd_pkg::OpClear;
    else if (sel < 30) op = mrd_pkg::OpRect;
    else if (sel < 50) op = mrd_pkg::OpHline;
    else if (sel < 70) op = mrd_pkg::OpBar;
    else if (sel < 95) op = mrd_pkg::OpRead;
    else op = 3'($urandom_range(7, 5));
    send_word(op, pick_coord(cur_w), pick_coord(cur_h), pick_size(), pick_size(),
              1'($urandom()), 1'($urandom()), $urandom_range(255), $urandom_range(4095));
  endtask

  initial begin
    int geo_w[6] = '{256, 8, 0, 511, 64, 100};
    int geo_h[6] = '{128, 1, 0, 255, 40, 17};
    idle_pct = 0;
    cur_w = 256;
    cur_h = 128;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(mrd_pkg::OpClear, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0);
    send_word(mrd_pkg::OpRead, 0, 0, 0, 0, 1'b0, 1'b0, 0, 4095);
    send_word(mrd_pkg::OpRect, 10, 5, 20, 9, 1'b1, 1'b1, 0, 0);
    send_word(mrd_pkg::OpRect, 3, 2, 30, 12, 1'b1, 1'b0, 0, 0);
    send_word(mrd_pkg::OpRect, -5, -3, 12, 8, 1'b1, 1'b0, 0, 0);
    send_word(mrd_pkg::OpRect, 250, 120, 20, 20, 1'b0, 1'b0, 0, 0);
    send_word(mrd_pkg::OpRect, 4, 4, 0, 5, 1'b1, 1'b1, 0, 0);
    send_word(mrd_pkg::OpRect, 4, 4, -32768, 32767, 1'b1, 1'b1, 0, 0);
    send_word(mrd_pkg::OpRect, -32768, -32768, 32767, 32767, 1'b1, 1'b0, 0, 0);
    send_word(mrd_pkg::OpRect, 40, 40, 1, 1, 1'b1, 1'b0, 0, 0);
    send_word(mrd_pkg::OpHline, 0, -1, 10, 0, 1'b1, 1'b0, 0, 0);
    send_word(mrd_pkg::OpHline, 0, 128, 10, 0, 1'b1, 1'b0, 0, 0);
    send_word(mrd_pkg::OpHline, -8, 60, 300, 0, 1'b1, 1'b0, 0, 0);
    send_word(mrd_pkg::OpBar, 20, 80, 2, 9, 1'b0, 1'b0, 50, 0);
    send_word(mrd_pkg::OpBar, 20, 90, 30, 7, 1'b0, 1'b0, 0, 0);
    send_word(mrd_pkg::OpBar, 20, 100, 30, 7, 1'b0, 1'b0, 100, 0);
    send_word(mrd_pkg::OpBar, 240, 110, 40, 6, 1'b0, 1'b0, 255, 0);
    send_word(mrd_pkg::OpBar, 60, 100, 17, 3, 1'b0, 1'b0, 37, 0);
    send_word(3'd5, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0);
    send_word(3'd6, 0, 0, 0, 0, 1'b1, 1'b1, 0, 0);
    send_word(3'd7, 0, 0, 0, 0, 1'b1, 1'b1, 255, 4095);
    send_word(mrd_pkg::OpRead, 0, 0, 0, 0, 1'b0, 1'b0, 0, 1234);
    send_word(mrd_pkg::OpClear, 0, 0, 0, 0, 1'b1, 1'b0, 0, 0);
    send_word(mrd_pkg::OpRead, 0, 0, 0, 0, 1'b0, 1'b0, 0, 2730);

    for (int p = 0; p < 6; p++) begin
      set_geometry(geo_w[p], geo_h[p]);
      for (int n = 0; n < 130; n++) begin
        idle_pct = (n < 40) ? 0 : ((n < 85) ? 75 : 15);
        if (n == 100) drain();
        random_word();
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("mono_rect_draw_engine regression: pass");
    else $display("mono_rect_draw_engine regression: fail");
    $finish;
  end

endmodule

// ===== mono_rect_draw_engine.f =====
+incdir+hw/rtl
hw/rtl/mrd_pkg.sv
hw/rtl/mrd_dp.sv
hw/rtl/mrd_ctrl.sv
hw/rtl/mono_rect_draw_engine.sv
hw/rtl/mrd_chk.sv
tb/mrd_checker.sv
tb/tb_top.sv
